// File: rtl/core/dhad_pkg.sv
// Shared types and constants for the detection head anchor decode block.
package dhad_pkg;

  // Limits on the per-anchor item counts
  localparam int unsigned MaxClasses = 128;
  localparam int unsigned MaxCoeffs  = 32;

  // Field widths
  localparam int unsigned OpW     = 2;
  localparam int unsigned CoordW  = 15;
  localparam int unsigned ScoreW  = 16;
  localparam int unsigned CoeffW  = 16;
  localparam int unsigned CornerW = 18;
  localparam int unsigned ClassW  = 8;
  localparam int unsigned CcntW   = 6;
  localparam int unsigned CidxW   = 5;

  // Stream and config port widths
  localparam int unsigned InDataW  = 96;
  localparam int unsigned OutDataW = 120;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Register reset values
  localparam logic [ScoreW-1:0] ThresholdRst  = 16'd16384;
  localparam logic [ClassW-1:0] ClassCountRst = 8'd80;
  localparam logic [CcntW-1:0]  CoeffCountRst = 6'd32;

  typedef enum logic [OpW-1:0] {
    OP_BOX   = 2'd0,
    OP_SCORE = 2'd1,
    OP_COEFF = 2'd2
  } op_e;

  typedef enum logic {
    KIND_BOX   = 1'b0,
    KIND_COEFF = 1'b1
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_THRESHOLD   = 2'd0,
    CFG_CLASS_COUNT = 2'd1,
    CFG_COEFF_COUNT = 2'd2
  } cfg_idx_e;

endpackage

// File: rtl/core/detection_head_anchor_decode.sv
// Anchor decode of a detection head: running class max, threshold, box corners, coefficients.
//
//  Channel   Direction  Payload                                         Handshake
//  s_axis    in         tuser: op; tdata: box, score, coefficient       tvalid/tready
//  m_axis    out        tuser: kind; tdata: corners, score, class, coef  tvalid/tready, tlast
//  cfg       in         cfg_index_i, cfg_data_i                          cfg_valid_i/cfg_ready_o
//
// One item per cycle while the output is not stalled: an accepted item waits in the input
// register while the running max, compare and corner adders settle, then moves on to the
// output register. Reset clears the anchor state and loads register defaults. A stalled
// output register holds the input register, which then holds the input side; both move
// again in the cycle m_axis_tready_i returns.
module detection_head_anchor_decode (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input stream
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // tdata, low to high: center_x, center_y, box_width, box_height, score_value,
  // coeff_value, zero fill
  input  logic [dhad_pkg::InDataW-1:0] s_axis_tdata_i,
  // tuser: op
  input  logic [dhad_pkg::OpW-1:0]     s_axis_tuser_i,
  // result stream
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // tdata, low to high: left, top, right, bottom, best_score, best_class, coeff_out,
  // coeff_index, zero fill
  output logic [dhad_pkg::OutDataW-1:0] m_axis_tdata_o,
  // tuser: kind
  output logic                         m_axis_tuser_o,
  output logic                         m_axis_tlast_o,
  // configuration writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [dhad_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [dhad_pkg::CfgDataW-1:0] cfg_data_i
);
  import dhad_pkg::*;

  // configuration registers
  logic [ScoreW-1:0] thresh_q;
  logic [ClassW-1:0] class_count_q;
  logic [CcntW-1:0]  coeff_count_q;

  // input register
  logic                in_valid_q;
  op_e                 op_q;
  logic [CoordW-1:0]   cx_q, cy_q, w_q, h_q;
  logic [ScoreW-1:0]   score_q;
  logic [CoeffW-1:0]   coeff_q;

  // anchor state
  logic [ScoreW-1:0]  run_max_q, run_max_d;
  logic [ClassW-1:0]  run_class_q, run_class_d;
  logic [ClassW-1:0]  class_cnt_q, class_cnt_d;
  logic [CcntW-1:0]   coeff_cnt_q, coeff_cnt_d;
  logic               keep_q, keep_d;
  logic [CornerW-1:0] box_q [4];
  logic [CornerW-1:0] box_d [4];

  // output register
  logic               out_valid_q;
  kind_e              kind_q, kind_d;
  logic [CornerW-1:0] res_box_q [4];
  logic [CornerW-1:0] res_box_d [4];
  logic [ScoreW-1:0]  res_score_q, res_score_d;
  logic [ClassW-1:0]  res_class_q, res_class_d;
  logic [CoeffW-1:0]  res_coeff_q, res_coeff_d;
  logic [CidxW-1:0]   res_cidx_q, res_cidx_d;
  logic               res_last_q, res_last_d;
  logic               emit;

  logic               in_xfer, advance;
  logic [ClassW-1:0]  eff_cls, cls_inc;
  logic [CcntW-1:0]   eff_cof, cof_inc;
  logic [CornerW-1:0] cx2, cy2, wz, hz;
  logic [ScoreW-1:0]  new_max;
  logic [ClassW-1:0]  new_class;

  assign cfg_ready_o     = 1'b1;
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  assign eff_cls = (class_count_q > ClassW'(MaxClasses)) ? ClassW'(MaxClasses) : class_count_q;
  assign eff_cof = (coeff_count_q > CcntW'(MaxCoeffs)) ? CcntW'(MaxCoeffs) : coeff_count_q;
  assign cls_inc = class_cnt_q + 1'b1;
  assign cof_inc = coeff_cnt_q + 1'b1;

  // corners are exact: 2*centre -/+ size in 18 bits
  assign cx2 = {2'b00, cx_q, 1'b0};
  assign cy2 = {2'b00, cy_q, 1'b0};
  assign wz  = {3'b000, w_q};
  assign hz  = {3'b000, h_q};

  assign new_max   = (score_q > run_max_q) ? score_q : run_max_q;
  assign new_class = (score_q > run_max_q) ? class_cnt_q : run_class_q;

  always_comb begin
    run_max_d   = run_max_q;
    run_class_d = run_class_q;
    class_cnt_d = class_cnt_q;
    coeff_cnt_d = coeff_cnt_q;
    keep_d      = keep_q;
    box_d       = box_q;
    emit        = 1'b0;
    kind_d      = KIND_BOX;
    res_box_d   = box_q;
    res_score_d = new_max;
    res_class_d = new_class;
    res_coeff_d = '0;
    res_cidx_d  = '0;
    res_last_d  = 1'b0;
    unique case (op_q)
      OP_BOX: begin
        run_max_d   = '0;
        run_class_d = '1;
        class_cnt_d = '0;
        coeff_cnt_d = '0;
        keep_d      = 1'b0;
        box_d[0]    = cx2 - wz;
        box_d[1]    = cy2 - hz;
        box_d[2]    = cx2 + wz;
        box_d[3]    = cy2 + hz;
      end
      OP_SCORE: begin
        if (class_cnt_q < eff_cls) begin
          run_max_d   = new_max;
          run_class_d = new_class;
          class_cnt_d = cls_inc;
          if (cls_inc == eff_cls && new_max >= thresh_q) begin
            emit = 1'b1;
            if (eff_cof == '0) begin
              res_last_d = 1'b1;
            end else begin
              keep_d      = 1'b1;
              coeff_cnt_d = '0;
            end
          end
        end
      end
      OP_COEFF: begin
        if (keep_q) begin
          if (coeff_cnt_q >= eff_cof) begin
            keep_d = 1'b0;
          end else begin
            emit        = 1'b1;
            kind_d      = KIND_COEFF;
            res_box_d   = '{default: '0};
            res_score_d = '0;
            res_class_d = '0;
            res_coeff_d = coeff_q;
            res_cidx_d  = coeff_cnt_q[CidxW-1:0];
            coeff_cnt_d = cof_inc;
            if (cof_inc == eff_cof) begin
              res_last_d = 1'b1;
              keep_d     = 1'b0;
            end
          end
        end
      end
      default: begin
        // unused op code: drop
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q      <= ThresholdRst;
      class_count_q <= ClassCountRst;
      coeff_count_q <= CoeffCountRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_THRESHOLD:   thresh_q      <= cfg_data_i[ScoreW-1:0];
        CFG_CLASS_COUNT: class_count_q <= cfg_data_i[ClassW-1:0];
        CFG_COEFF_COUNT: coeff_count_q <= cfg_data_i[CcntW-1:0];
        default: begin
          // no register at this index
        end
      endcase
    end
  end

  // control: input valid, anchor state, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      run_max_q   <= '0;
      run_class_q <= '1;
      class_cnt_q <= '0;
      coeff_cnt_q <= '0;
      keep_q      <= 1'b0;
      box_q       <= '{default: '0};
    end else begin
      if (in_xfer) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= emit;
        run_max_q   <= run_max_d;
        run_class_q <= run_class_d;
        class_cnt_q <= class_cnt_d;
        coeff_cnt_q <= coeff_cnt_d;
        keep_q      <= keep_d;
        box_q       <= box_d;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q    <= op_e'(s_axis_tuser_i);
      cx_q    <= s_axis_tdata_i[14:0];
      cy_q    <= s_axis_tdata_i[29:15];
      w_q     <= s_axis_tdata_i[44:30];
      h_q     <= s_axis_tdata_i[59:45];
      score_q <= s_axis_tdata_i[75:60];
      coeff_q <= s_axis_tdata_i[91:76];
    end
    if (advance && emit) begin
      kind_q      <= kind_d;
      res_box_q   <= res_box_d;
      res_score_q <= res_score_d;
      res_class_q <= res_class_d;
      res_coeff_q <= res_coeff_d;
      res_cidx_q  <= res_cidx_d;
      res_last_q  <= res_last_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = kind_q;
  assign m_axis_tlast_o  = res_last_q;
  assign m_axis_tdata_o  = {3'b000, res_cidx_q, res_coeff_q, res_class_q, res_score_q,
                            res_box_q[3], res_box_q[2], res_box_q[1], res_box_q[0]};

endmodule

// File: sim/tb.sv
// Testbench for the detection head anchor decode block: directed table, then random anchors.
`timescale 1ns / 100ps

module tb;
  import dhad_pkg::*;

  localparam int SettleCycles = 8;
  localparam int HoldCycles   = 400;
  localparam int Phases       = 10;
  localparam int LimitNs      = 400_000;

  localparam logic [OpW-1:0] OpSpare = 2'd3;

  typedef struct {
    kind_e                     kind;
    logic signed [CornerW-1:0] left;
    logic signed [CornerW-1:0] top;
    logic signed [CornerW-1:0] right;
    logic signed [CornerW-1:0] bottom;
    logic [ScoreW-1:0]         best;
    logic signed [ClassW-1:0]  cls;
    logic signed [CoeffW-1:0]  coeff;
    logic [CidxW-1:0]          idx;
    logic                      last;
  } res_t;

  // One row of stimulus: either a register write or an input item
  typedef struct {
    bit                  is_reg;
    cfg_idx_e            reg_idx;
    logic [CfgDataW-1:0] reg_val;
    logic [OpW-1:0]      op;
    logic [InDataW-1:0]  payload;
    bit                  typed;
    res_t                want;
  } step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [InDataW-1:0]  in_data = '0;
  logic [OpW-1:0]      in_op = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [OutDataW-1:0] out_data;
  logic                out_kind;
  logic                out_last;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  // Register copies and anchor state of the decode predictor
  logic [ScoreW-1:0]         thr_level   = ThresholdRst;
  logic [ClassW-1:0]         class_total = ClassCountRst;
  logic [CcntW-1:0]          coeff_total = CoeffCountRst;
  logic [ScoreW-1:0]         top_score   = '0;
  logic signed [ClassW-1:0]  top_class   = -8'sd1;
  logic [ClassW-1:0]         score_seen  = '0;
  logic [CcntW-1:0]          coeff_seen  = '0;
  logic signed [CornerW-1:0] corner [4]  = '{default: '0};
  bit                        kept        = 1'b0;

  res_t decoded_due[$];
  int   fault_count = 0;
  bit   steady = 1'b0;
  bit   hold_req = 1'b0;

  always #1 clk = ~clk;

  detection_head_anchor_decode i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_data),
    .s_axis_tuser_i  (in_op),
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_data),
    .m_axis_tuser_o  (out_kind),
    .m_axis_tlast_o  (out_last),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  function automatic res_t box_res(int l, int t, int r, int b, int best, int cls, bit last);
    res_t x;
    x.kind   = KIND_BOX;
    x.left   = 18'(l);
    x.top    = 18'(t);
    x.right  = 18'(r);
    x.bottom = 18'(b);
    x.best   = 16'(best);
    x.cls    = 8'(cls);
    x.coeff  = '0;
    x.idx    = '0;
    x.last   = last;
    return x;
  endfunction

  function automatic res_t coeff_res(int v, int idx, bit last);
    res_t x;
    x = box_res(0, 0, 0, 0, 0, 0, last);
    x.kind  = KIND_COEFF;
    x.coeff = 16'(v);
    x.idx   = 5'(idx);
    return x;
  endfunction

  function automatic step_t item_row(logic [OpW-1:0] op, int cx, int cy, int w, int h,
                                     int sc, int cf);
    step_t s;
    s.is_reg  = 1'b0;
    s.reg_idx = CFG_THRESHOLD;
    s.reg_val = '0;
    s.op      = op;
    s.payload = {4'b0, 16'(cf), 16'(sc), 15'(h), 15'(w), 15'(cy), 15'(cx)};
    s.typed   = 1'b0;
    s.want    = coeff_res(0, 0, 1'b0);
    return s;
  endfunction

  function automatic step_t reg_row(cfg_idx_e i, int v);
    step_t s;
    s = item_row(OP_BOX, 0, 0, 0, 0, 0, 0);
    s.is_reg  = 1'b1;
    s.reg_idx = i;
    s.reg_val = 16'(v);
    return s;
  endfunction

  // Fields an item does not use carry random junk
  function automatic step_t box_row(int cx, int cy, int w, int h);
    return item_row(OP_BOX, cx, cy, w, h, $urandom, $urandom);
  endfunction

  function automatic step_t score_row(int s);
    return item_row(OP_SCORE, $urandom, $urandom, $urandom, $urandom, s, $urandom);
  endfunction

  function automatic step_t coeff_row(int c);
    return item_row(OP_COEFF, $urandom, $urandom, $urandom, $urandom, $urandom, c);
  endfunction

  function automatic step_t with_want(step_t s, res_t w);
    s.typed = 1'b1;
    s.want  = w;
    return s;
  endfunction

  // Bias scores toward zero, full scale and the current threshold
  function automatic int pick_score();
    int v;
    case ($urandom_range(0, 7))
      0: v = 0;
      1: v = 65535;
      2, 3: begin
        v = int'(thr_level) + int'($urandom_range(0, 4)) - 2;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
      end
      default: v = int'($urandom_range(0, 65535));
    endcase
    return v;
  endfunction

  task automatic decode_step(input logic [OpW-1:0] op, input logic [InDataW-1:0] d,
                             output bit hit, output res_t r);
    logic [ClassW-1:0] cls_lim;
    logic [CcntW-1:0]  cof_lim;
    logic [ScoreW-1:0] s;
    int cx, cy, w, h;
    cls_lim = (class_total > MaxClasses) ? 8'(MaxClasses) : class_total;
    cof_lim = (coeff_total > MaxCoeffs) ? 6'(MaxCoeffs) : coeff_total;
    hit = 1'b0;
    r = coeff_res(0, 0, 1'b0);
    case (op)
      OP_BOX: begin
        cx = int'(d[14:0]);
        cy = int'(d[29:15]);
        w  = int'(d[44:30]);
        h  = int'(d[59:45]);
        corner[0] = 18'(2 * cx - w);
        corner[1] = 18'(2 * cy - h);
        corner[2] = 18'(2 * cx + w);
        corner[3] = 18'(2 * cy + h);
        top_score  = '0;
        top_class  = -8'sd1;
        score_seen = '0;
        coeff_seen = '0;
        kept       = 1'b0;
      end
      OP_SCORE: begin
        s = d[75:60];
        if (score_seen < cls_lim) begin
          if (s > top_score) begin
            top_score = s;
            top_class = score_seen;
          end
          score_seen++;
          if (score_seen == cls_lim && top_score >= thr_level) begin
            hit = 1'b1;
            r = box_res(corner[0], corner[1], corner[2], corner[3], top_score, top_class,
                        cof_lim == 0);
            if (cof_lim != 0) begin
              kept       = 1'b1;
              coeff_seen = '0;
            end
          end
        end
      end
      OP_COEFF: begin
        if (kept) begin
          // past the count: the anchor ends without a last mark
          if (coeff_seen >= cof_lim) begin
            kept = 1'b0;
          end else begin
            hit = 1'b1;
            r = coeff_res(int'($signed(d[91:76])), coeff_seen, coeff_seen + 1 == cof_lim);
            coeff_seen++;
            if (coeff_seen == cof_lim) kept = 1'b0;
          end
        end
      end
      default: ;
    endcase
  endtask

  // Drop valid, wait for the results still due, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (decoded_due.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic run_step(input step_t s);
    bit   hit;
    res_t r;
    if (s.is_reg) begin
      settle();
      cfg_valid <= 1'b1;
      cfg_index <= s.reg_idx;
      cfg_data  <= s.reg_val;
      do @(posedge clk); while (!cfg_ready);
      case (s.reg_idx)
        CFG_THRESHOLD:   thr_level   = s.reg_val;
        CFG_CLASS_COUNT: class_total = s.reg_val[ClassW-1:0];
        CFG_COEFF_COUNT: coeff_total = s.reg_val[CcntW-1:0];
        default: ;
      endcase
      @(negedge clk);
      cfg_valid <= 1'b0;
    end else begin
      while (!steady && $urandom_range(0, 99) < 25) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
      in_valid <= 1'b1;
      in_op    <= s.op;
      in_data  <= s.payload;
      do @(posedge clk); while (!in_ready);
      decode_step(s.op, s.payload, hit, r);
      if (s.typed) decoded_due.insert(decoded_due.size(), s.want);
      else if (hit) decoded_due.insert(decoded_due.size(), r);
      @(negedge clk);
    end
  endtask

  task automatic field_check(input string name, input logic signed [31:0] want_v,
                             input logic signed [31:0] got_v);
    if (got_v !== want_v) begin
      fault_count++;
      $display("%0t: %s expected %0d, actual %0d", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin : result_check
    res_t got;
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      got.kind   = kind_e'(out_kind);
      got.left   = out_data[17:0];
      got.top    = out_data[35:18];
      got.right  = out_data[53:36];
      got.bottom = out_data[71:54];
      got.best   = out_data[87:72];
      got.cls    = out_data[95:88];
      got.coeff  = out_data[111:96];
      got.idx    = out_data[116:112];
      got.last   = out_last;
      if (decoded_due.size() == 0) begin
        fault_count++;
        $display("%0t: result with nothing due, kind %0d coeff %0d", $time, out_kind,
                 got.coeff);
      end else begin
        want = decoded_due.pop_front();
        field_check("kind", want.kind, got.kind);
        field_check("left", want.left, got.left);
        field_check("top", want.top, got.top);
        field_check("right", want.right, got.right);
        field_check("bottom", want.bottom, got.bottom);
        field_check("best_score", want.best, got.best);
        field_check("best_class", want.cls, got.cls);
        field_check("coeff_out", want.coeff, got.coeff);
        field_check("coeff_index", want.idx, got.idx);
        field_check("last", want.last, got.last);
      end
    end
  end

  // Result side: random stalls, one long hold-off on request
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(0, 99) >= 25);
      end
    end
  end

  initial begin : stimulus
    step_t plan[$];
    int    budget, sent, nsc, ncf, lim_cls, lim_cof, thr;
    logic [ClassW-1:0] cls;
    logic [CcntW-1:0]  cof;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    plan.insert(plan.size(), reg_row(CFG_CLASS_COUNT, 2));
    plan.insert(plan.size(), reg_row(CFG_COEFF_COUNT, 1));
    // scores with no box go to the all-zero box left by reset
    plan.insert(plan.size(), score_row(0));
    plan.insert(plan.size(), with_want(score_row(65535),
                                       box_res(0, 0, 0, 0, 65535, 1, 1'b0)));
    plan.insert(plan.size(), with_want(coeff_row(-32768), coeff_res(-32768, 0, 1'b1)));
    plan.insert(plan.size(), coeff_row(32767));
    plan.insert(plan.size(), box_row(32767, 32767, 32767, 32767));
    plan.insert(plan.size(), score_row(16383));
    plan.insert(plan.size(), score_row(0));
    plan.insert(plan.size(), coeff_row(5));
    plan.insert(plan.size(), score_row(65535));
    plan.insert(plan.size(), box_row(0, 0, 32767, 32767));
    plan.insert(plan.size(), score_row(16384));
    // a tie keeps the earlier class
    plan.insert(plan.size(), with_want(score_row(16384),
                                       box_res(-32767, -32767, 32767, 32767, 16384, 0,
                                               1'b0)));
    plan.insert(plan.size(), item_row(OpSpare, $urandom, $urandom, $urandom, $urandom,
                                      $urandom, $urandom));
    plan.insert(plan.size(), with_want(coeff_row(32767), coeff_res(32767, 0, 1'b1)));
    // no coefficients: the box carries the last mark
    plan.insert(plan.size(), reg_row(CFG_COEFF_COUNT, 0));
    plan.insert(plan.size(), reg_row(CFG_THRESHOLD, 0));
    plan.insert(plan.size(), box_row(100, 200, 3, 7));
    plan.insert(plan.size(), score_row(0));
    plan.insert(plan.size(), with_want(score_row(0),
                                       box_res(197, 393, 203, 407, 0, -1, 1'b1)));
    // shrink the coefficient count under a kept anchor
    plan.insert(plan.size(), reg_row(CFG_COEFF_COUNT, 3));
    plan.insert(plan.size(), box_row(5, 5, 5, 5));
    plan.insert(plan.size(), score_row(100));
    plan.insert(plan.size(), score_row(200));
    plan.insert(plan.size(), coeff_row(10));
    plan.insert(plan.size(), coeff_row(20));
    plan.insert(plan.size(), reg_row(CFG_COEFF_COUNT, 1));
    plan.insert(plan.size(), coeff_row(30));
    // shrink the class count mid-anchor, then zero classes
    plan.insert(plan.size(), reg_row(CFG_CLASS_COUNT, 3));
    plan.insert(plan.size(), box_row(1, 2, 3, 4));
    plan.insert(plan.size(), score_row(9));
    plan.insert(plan.size(), score_row(8));
    plan.insert(plan.size(), reg_row(CFG_CLASS_COUNT, 1));
    plan.insert(plan.size(), score_row(65535));
    plan.insert(plan.size(), reg_row(CFG_CLASS_COUNT, 0));
    plan.insert(plan.size(), box_row($urandom, $urandom, $urandom, $urandom));
    plan.insert(plan.size(), score_row(65535));

    foreach (plan[k]) run_step(plan[k]);

    for (int ph = 0; ph < Phases; ph++) begin
      case (ph)
        0: begin thr = 0; cls = 8'd1; cof = 6'd0; end
        1: begin thr = 65535; cls = 8'(MaxClasses); cof = 6'(MaxCoeffs); end
        2: begin
          thr = int'($urandom_range(0, 65535));
          cls = 8'($urandom_range(MaxClasses + 1, 255));
          cof = 6'($urandom_range(MaxCoeffs + 1, 63));
        end
        default: begin
          thr = int'($urandom_range(0, 65535));
          cls = 8'($urandom_range(1, 6));
          cof = 6'($urandom_range(0, 5));
        end
      endcase
      // upper data bits fall outside the registers and are random
      run_step(reg_row(CFG_THRESHOLD, thr));
      run_step(reg_row(CFG_CLASS_COUNT, int'({8'($urandom), cls})));
      run_step(reg_row(CFG_COEFF_COUNT, int'({10'($urandom), cof})));
      if (ph == 5) hold_req = 1'b1;
      steady  = (ph == 7 || ph == 8);
      lim_cls = (class_total > MaxClasses) ? MaxClasses : class_total;
      lim_cof = (coeff_total > MaxCoeffs) ? MaxCoeffs : coeff_total;
      budget  = (ph == 1 || ph == 2) ? 350 : 100;
      sent    = 0;
      while (sent < budget) begin
        if ($urandom_range(0, 99) < 8) begin
          case ($urandom_range(0, 2))
            0: run_step(score_row(pick_score()));
            1: run_step(coeff_row($urandom));
            default: run_step(item_row(OpSpare, $urandom, $urandom, $urandom, $urandom,
                                       $urandom, $urandom));
          endcase
        end else begin
          nsc = lim_cls;
          ncf = lim_cof;
          // now and then a short or overlong anchor
          if ($urandom_range(0, 9) == 0) nsc = $urandom_range(0, lim_cls + 2);
          if ($urandom_range(0, 9) == 0) ncf = $urandom_range(0, lim_cof + 2);
          run_step(box_row($urandom, $urandom, $urandom, $urandom));
          repeat (nsc) run_step(score_row(pick_score()));
          repeat (ncf) run_step(coeff_row($urandom));
          sent += 1 + nsc + ncf;
        end
      end
    end

    steady = 1'b0;
    settle();
    if (fault_count == 0) begin
      $display("PASS detection_head_anchor_decode");
    end else begin
      $display("FAIL detection_head_anchor_decode");
    end
    $finish;
  end

  initial begin : watchdog
    #(LimitNs);
    $display("FAIL detection_head_anchor_decode");
    $finish;
  end

endmodule
